FILE: rtl/dotq_pkg.sv
// Package: shared types, sizes and codes for the deadline-ordered timer queue.
package dotq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 48;
   localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] FUNC_SCHEDULE = 2'd0;
   localparam logic [1:0] FUNC_TICK     = 2'd1;
   localparam logic [1:0] FUNC_CANCEL   = 2'd2;

   localparam logic [1:0] RSP_NONE    = 2'd0;
   localparam logic [1:0] RSP_FIRED   = 2'd1;
   localparam logic [1:0] RSP_DROPPED = 2'd2;

   localparam logic [3:0] CMD_NONE   = 4'd0;
   localparam logic [3:0] CMD_LOAD   = 4'd1;
   localparam logic [3:0] CMD_ARM    = 4'd2;
   localparam logic [3:0] CMD_DROP   = 4'd3;
   localparam logic [3:0] CMD_INSERT = 4'd4;
   localparam logic [3:0] CMD_CANCEL = 4'd5;
   localparam logic [3:0] CMD_ACK    = 4'd6;
   localparam logic [3:0] CMD_REFILL = 4'd7;
   localparam logic [3:0] CMD_FIRE   = 4'd8;

   typedef struct packed {
      logic [1:0]           func;
      logic [7:0]           task_id;
      logic [TIME_BITS-1:0] deadline;
      logic [TIME_BITS-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] fired_task;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       armed_valid;
      logic       armed_due;
      logic       next_due;
      logic       queue_empty;
      logic       queue_full;
      logic       stopped;
      logic       out_free;
   } stat_type;

endpackage

FILE: rtl/dotq_ctrl.sv
// Controller: sequences accept, schedule, tick and cancel steps for the timer queue.
module dotq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dotq_pkg::stat_type stat,
   output dotq_pkg::cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = dotq_pkg::CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = dotq_pkg::CMD_LOAD;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
               case (stat.func)
                  dotq_pkg::FUNC_SCHEDULE: begin
                     if (!stat.armed_valid && stat.queue_empty) begin
                        cmd.op = dotq_pkg::CMD_ARM;
                     end else if (stat.queue_full) begin
                        cmd.op = dotq_pkg::CMD_DROP;
                     end else begin
                        cmd.op = dotq_pkg::CMD_INSERT;
                     end
                  end
                  dotq_pkg::FUNC_TICK: begin
                     if (stat.stopped) begin
                        cmd.op = dotq_pkg::CMD_ACK;
                     end else if (!stat.armed_valid && !stat.queue_empty) begin
                        cmd.op   = dotq_pkg::CMD_REFILL;
                        state_in = ST_EXEC;
                     end else if (stat.armed_valid && stat.armed_due) begin
                        cmd.op = dotq_pkg::CMD_FIRE;
                        if (stat.next_due) begin
                           state_in = ST_EXEC;
                        end
                     end else begin
                        cmd.op = dotq_pkg::CMD_ACK;
                     end
                  end
                  dotq_pkg::FUNC_CANCEL: begin
                     cmd.op = dotq_pkg::CMD_CANCEL;
                  end
                  default: begin
                     cmd.op = dotq_pkg::CMD_ACK;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/dotq_dp.sv
// Datapath: request latch, armed slot, sorted pending queue and result register.
module dotq_dp (
   input  logic               clock,
   input  logic               reset,
   input  dotq_pkg::req_type  req_data,
   input  dotq_pkg::cmd_type  cmd,
   output dotq_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dotq_pkg::rsp_type  rsp_data
);

   localparam int N  = dotq_pkg::QUEUE_DEPTH;
   localparam int TB = dotq_pkg::TIME_BITS;
   localparam int CB = dotq_pkg::CNT_BITS;

   dotq_pkg::req_type req_ff;

   logic          armed_valid_ff, armed_valid_in;
   logic [TB-1:0] armed_dl_ff, armed_dl_in;
   logic [7:0]    armed_task_ff, armed_task_in;
   logic          stopped_ff, stopped_in;
   logic [CB-1:0] count_ff, count_in;
   logic [TB-1:0] q_dl_ff   [N];
   logic [TB-1:0] q_dl_in   [N];
   logic [7:0]    q_task_ff [N];
   logic [7:0]    q_task_in [N];
   logic [N-1:0]  le;

   logic              rsp_valid_ff, rsp_valid_in;
   dotq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic out_free;
   logic emit;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stat.func        = req_ff.func;
      stat.armed_valid = armed_valid_ff;
      stat.armed_due   = (armed_dl_ff <= req_ff.now_time);
      stat.next_due    = (count_ff != '0) && (q_dl_ff[0] <= req_ff.now_time);
      stat.queue_empty = (count_ff == '0);
      stat.queue_full  = (count_ff >= CB'(N));
      stat.stopped     = stopped_ff;
      stat.out_free    = out_free;
   end

   // entries at or before the new deadline keep their place
   always_comb begin
      for (int i = 0; i < N; i++) begin
         le[i] = (CB'(i) < count_ff) && (q_dl_ff[i] <= req_ff.deadline);
      end
   end

   always_comb begin
      armed_valid_in = armed_valid_ff;
      armed_dl_in    = armed_dl_ff;
      armed_task_in  = armed_task_ff;
      stopped_in     = stopped_ff;
      count_in       = count_ff;
      q_dl_in        = q_dl_ff;
      q_task_in      = q_task_ff;
      emit           = 1'b0;
      rsp_data_in.status     = dotq_pkg::RSP_NONE;
      rsp_data_in.fired_task = 8'd0;
      rsp_data_in.last       = 1'b1;
      case (cmd.op)
         dotq_pkg::CMD_ARM: begin
            armed_valid_in = 1'b1;
            armed_dl_in    = req_ff.deadline;
            armed_task_in  = req_ff.task_id;
            emit           = 1'b1;
         end
         dotq_pkg::CMD_DROP: begin
            rsp_data_in.status = dotq_pkg::RSP_DROPPED;
            emit               = 1'b1;
         end
         dotq_pkg::CMD_INSERT: begin
            if (!le[0]) begin
               q_dl_in[0]   = req_ff.deadline;
               q_task_in[0] = req_ff.task_id;
            end
            for (int i = 1; i < N; i++) begin
               if (!le[i]) begin
                  if (le[i-1]) begin
                     q_dl_in[i]   = req_ff.deadline;
                     q_task_in[i] = req_ff.task_id;
                  end else begin
                     q_dl_in[i]   = q_dl_ff[i-1];
                     q_task_in[i] = q_task_ff[i-1];
                  end
               end
            end
            count_in = count_ff + CB'(1);
            emit     = 1'b1;
         end
         dotq_pkg::CMD_CANCEL: begin
            if (!stopped_ff) begin
               stopped_in     = 1'b1;
               armed_valid_in = 1'b0;
            end
            emit = 1'b1;
         end
         dotq_pkg::CMD_ACK: begin
            emit = 1'b1;
         end
         dotq_pkg::CMD_REFILL, dotq_pkg::CMD_FIRE: begin
            if (cmd.op == dotq_pkg::CMD_FIRE) begin
               rsp_data_in.status     = dotq_pkg::RSP_FIRED;
               rsp_data_in.fired_task = armed_task_ff;
               rsp_data_in.last       = !stat.next_due;
               emit                   = 1'b1;
            end
            if (count_ff == '0) begin
               armed_valid_in = 1'b0;
            end else begin
               armed_valid_in = 1'b1;
               armed_dl_in    = q_dl_ff[0];
               armed_task_in  = q_task_ff[0];
               for (int i = 0; i < N - 1; i++) begin
                  q_dl_in[i]   = q_dl_ff[i+1];
                  q_task_in[i] = q_task_ff[i+1];
               end
               count_in = count_ff - CB'(1);
            end
         end
         default: begin
         end
      endcase
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == dotq_pkg::CMD_LOAD) begin
         req_ff <= req_data;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
      armed_dl_ff   <= armed_dl_in;
      armed_task_ff <= armed_task_in;
      q_dl_ff       <= q_dl_in;
      q_task_ff     <= q_task_in;
      if (reset) begin
         armed_valid_ff <= 1'b0;
         stopped_ff     <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         armed_valid_ff <= armed_valid_in;
         stopped_ff     <= stopped_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(N))
      else $error("pending count above queue depth");

   a_fire_not_stopped: assert property (@(posedge clock) disable iff (reset)
      cmd.op == dotq_pkg::CMD_FIRE |-> !stopped_ff && armed_valid_ff)
      else $error("fire while stopped or slot empty");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CB'(2) |-> q_dl_ff[0] <= q_dl_ff[1])
      else $error("queue front out of order");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result written over a pending result");
`endif

endmodule

FILE: rtl/deadline_ordered_timer_queue.sv
// Top level: deadline-ordered timer queue, controller plus datapath.
// Each request is latched into the request register and worked from there: a
// schedule request (armed directly when the slot and queue are empty, else a
// sorted insert by parallel compare over the 16-entry queue), a cancel or an
// idle tick (which may first refill the armed slot) gives one response. A tick
// that fires k tasks (k >= 1) gives k responses, one per cycle while rsp_stall
// does not hold the result, after refilling an empty armed slot; the last
// response carries last=1. Equal deadlines fire in arrival order. A schedule
// into a full queue returns status 2 and is dropped. After a cancel nothing
// ever fires again. The response register lets a result wait under rsp_stall;
// no new request is taken until the current one has written all its responses.
module deadline_ordered_timer_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dotq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dotq_pkg::rsp_type rsp_data
);

   dotq_pkg::cmd_type  cmd;
   dotq_pkg::stat_type stat;

   dotq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dotq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
